>>> rtl/mft_pkg.sv
// Shared types, constants and codes for the multicast filter table unit.
// Used by every module under rtl/; depends on nothing.
package mft_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int COUNT_LIMIT   = 255;
    localparam int QUEUE_DEPTH   = 2;

    localparam int ADDR_W  = 48;
    localparam int COUNT_W = 8;
    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int GROUP_BIT = 40;

    localparam logic [COUNT_W-1:0] EFF_LIMIT =
        (COUNT_LIMIT > 255) ? 8'd255 : COUNT_W'(COUNT_LIMIT);
    localparam logic [ADDR_W-1:0] BCAST_ADDR = '1;

    // input opcodes
    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_DEL      = 2'd1;
    localparam logic [1:0] OP_CLASSIFY = 2'd2;

    // work handed to the table engine
    localparam logic [1:0] ACT_DIRECT = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_DEL    = 2'd2;
    localparam logic [1:0] ACT_LOOKUP = 2'd3;

    localparam logic [1:0] MK_NONE    = 2'd0;
    localparam logic [1:0] MK_STATION = 2'd1;
    localparam logic [1:0] MK_BCAST   = 2'd2;
    localparam logic [1:0] MK_TABLE   = 2'd3;

    // status in bit 0 upward to ref_count
    typedef struct packed {
        logic [COUNT_W-1:0] ref_count;
        logic [1:0]         match_kind;
        logic               accept;
        logic               status;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] cnt;
    } t_entry;

    typedef struct packed {
        logic [1:0]        act;
        logic [ADDR_W-1:0] addr;
        t_result           res;
    } t_cmd;

endpackage

>>> rtl/mft_front.sv
// Front end: takes input items, holds the station address, classifies each
// item into a direct result or a table job. Depends on mft_pkg.
module mft_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [mft_pkg::ADDR_W-1:0] i_cfg_wr_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_opcode,
    input  logic [mft_pkg::ADDR_W-1:0] i_addr,
    input  logic                      i_q_full,
    output logic                      o_push,
    output mft_pkg::t_cmd             o_cmd
);
    import mft_pkg::*;

    logic [ADDR_W-1:0] r_station;
    logic [ADDR_W-1:0] n_station;

    assign n_station = i_cfg_wr_en ? i_cfg_wr_data : r_station;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station <= '0;
        end else begin
            r_station <= n_station;
        end
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_cmd      = '0;
        o_cmd.addr = i_addr;
        case (i_opcode)
            OP_ADD: begin
                o_cmd.act = ACT_ADD;
            end
            OP_DEL: begin
                o_cmd.act = ACT_DEL;
            end
            OP_CLASSIFY: begin
                // station beats broadcast beats table
                o_cmd.act = ACT_DIRECT;
                if (i_addr == r_station) begin
                    o_cmd.res.match_kind = MK_STATION;
                    o_cmd.res.accept     = 1'b1;
                end else if (i_addr == BCAST_ADDR) begin
                    o_cmd.res.match_kind = MK_BCAST;
                    o_cmd.res.accept     = 1'b1;
                end else if (i_addr[GROUP_BIT]) begin
                    o_cmd.act = ACT_LOOKUP;
                end
            end
            default: begin
                o_cmd.act        = ACT_DIRECT;
                o_cmd.res.status = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/mft_fifo.sv
// Short command queue between front end and table engine.
// Depends on mft_pkg for the command type and depth.
module mft_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mft_pkg::t_cmd i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output mft_pkg::t_cmd o_pop_data,
    output logic          o_empty
);
    import mft_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full     = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty    = (r_cnt == '0);
    assign o_pop_data = r_mem[r_rptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

>>> rtl/mft_back.sv
// Table engine: address/count memory, linear search, count update,
// delete-and-compact, and the output register. Depends on mft_pkg.
module mft_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  mft_pkg::t_cmd   i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output mft_pkg::t_result o_result
);
    import mft_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_SHRD = 3'd3;
    localparam logic [2:0] S_SHWR = 3'd4;

    t_entry            r_mem [TABLE_ENTRIES];
    t_entry            r_rd_data;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_used, n_used;
    t_cmd              r_cmd, n_cmd;
    logic              r_out_vld, n_out_vld;
    t_result           r_out, n_out;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_entry            mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic              out_free;
    logic              done;
    t_result           res;
    logic [CNT_W:0]    idx_nx;

    assign out_free = !r_out_vld || i_ready;
    assign idx_nx   = {1'b0, r_idx} + (CNT_W + 1)'(1);
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_used    = r_used;
        n_cmd     = r_cmd;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_waddr = r_idx[IDX_W-1:0];
        mem_wdata = r_rd_data;
        mem_raddr = r_idx[IDX_W-1:0];
        o_pop     = 1'b0;
        done      = 1'b0;
        res       = '0;

        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_idx = '0;
                    if (i_cmd.act == ACT_DIRECT) begin
                        n_out_vld = 1'b1;
                        n_out     = i_cmd.res;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (r_idx == r_used) begin
                    // searched every entry without a hit
                    done = 1'b1;
                    case (r_cmd.act)
                        ACT_ADD: begin
                            if (r_used >= CNT_W'(TABLE_ENTRIES)) begin
                                res.status = 1'b1;
                            end else begin
                                mem_we        = 1'b1;
                                mem_waddr     = r_used[IDX_W-1:0];
                                mem_wdata     = '{addr: r_cmd.addr, cnt: COUNT_W'(1)};
                                n_used        = r_used + CNT_W'(1);
                                res.ref_count = COUNT_W'(1);
                            end
                        end
                        ACT_DEL: begin
                            res.status = 1'b1;
                        end
                        default: begin
                            res = '0;
                        end
                    endcase
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_rd_data.addr == r_cmd.addr) begin
                    done = 1'b1;
                    case (r_cmd.act)
                        ACT_ADD: begin
                            if (r_rd_data.cnt >= EFF_LIMIT) begin
                                res.status    = 1'b1;
                                res.ref_count = r_rd_data.cnt;
                            end else begin
                                mem_we        = 1'b1;
                                mem_wdata     = '{addr: r_cmd.addr,
                                                  cnt: r_rd_data.cnt + COUNT_W'(1)};
                                res.ref_count = r_rd_data.cnt + COUNT_W'(1);
                            end
                        end
                        ACT_DEL: begin
                            if (r_rd_data.cnt > COUNT_W'(1)) begin
                                mem_we        = 1'b1;
                                mem_wdata     = '{addr: r_cmd.addr,
                                                  cnt: r_rd_data.cnt - COUNT_W'(1)};
                                res.ref_count = r_rd_data.cnt - COUNT_W'(1);
                            end else begin
                                // last reference: close the gap first
                                done    = 1'b0;
                                n_state = S_SHRD;
                            end
                        end
                        default: begin
                            res.accept     = 1'b1;
                            res.match_kind = MK_TABLE;
                        end
                    endcase
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_READ;
                end
            end
            S_SHRD: begin
                if (idx_nx >= {1'b0, r_used}) begin
                    n_used = r_used - CNT_W'(1);
                    done   = 1'b1;
                end else begin
                    mem_raddr = idx_nx[IDX_W-1:0];
                    n_state   = S_SHWR;
                end
            end
            S_SHWR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rd_data;
                n_idx     = r_idx + CNT_W'(1);
                n_state   = S_SHRD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (done) begin
            n_out_vld = 1'b1;
            n_out     = res;
            n_state   = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_used    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_used    <= n_used;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_shift_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHRD || r_state == S_SHWR) |-> (r_used != '0))
        else $error("compaction with empty table");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_used != $past(r_used)) |->
        (r_used == $past(r_used) + CNT_W'(1) || r_used + CNT_W'(1) == $past(r_used)))
        else $error("entry count jumped");

    a_grow_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_used == $past(r_used) + CNT_W'(1)) |->
        ($past(r_cmd.act) == ACT_ADD && $past(r_state) == S_READ))
        else $error("entry count grew outside an add");

    a_busy_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP || r_state == S_SHWR) |-> !r_out_vld)
        else $error("result pending while table job runs");

endmodule

>>> rtl/multicast_filter_table_unit.sv
// Multicast filter table unit: front end, command queue, table engine.
// Items that need no table pass straight to the output register; a table job reads and compares
// each entry in turn, and a delete that frees an entry then moves each later entry down one place.
// Throughput: 1 item/cycle between table jobs while the output is not stalled; while a job runs
// the table walk holds the engine, and the 2-deep queue lets new items enter meanwhile.
// Synchronous active-low reset empties table and queue, clears station; no clearing pass.
module multicast_filter_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [47:0] i_cfg_wr_data,  // station_address
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata, // mac_address
    input  logic [1:0]  i_s_axis_tuser, // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata  // status, accept, match_kind[1:0], ref_count[7:0], 4'b0
);
    import mft_pkg::*;

    t_cmd    front_cmd;
    t_cmd    q_cmd;
    logic    front_push;
    logic    q_full;
    logic    q_empty;
    logic    back_pop;
    t_result back_res;

    mft_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_opcode      (i_s_axis_tuser),
        .i_addr        (i_s_axis_tdata),
        .i_q_full      (q_full),
        .o_push        (front_push),
        .o_cmd         (front_cmd)
    );

    mft_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_push),
        .i_push_data (front_cmd),
        .o_full      (q_full),
        .i_pop       (back_pop),
        .o_pop_data  (q_cmd),
        .o_empty     (q_empty)
    );

    mft_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_cmd    (q_cmd),
        .o_pop    (back_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (back_res)
    );

    assign o_m_axis_tdata = {4'b0000, back_res};

endmodule
